>>> design/tkr_pkg.sv
package tkr_pkg;

	localparam int CAPACITY = 64;
	localparam int ID_BITS = 16;
	localparam int KEY_BITS = 48;
	localparam int CNT_BITS = $clog2(CAPACITY + 1);
	localparam int IDX_BITS = $clog2(CAPACITY);
	localparam int CFG_IDX_BITS = 3;

	localparam logic [1:0] MODE_MAX_ITEMS = 2'd0;
	localparam logic [1:0] MODE_CUTOFF = 2'd1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CHART_MODE = 3'd0,
		REG_CHART_SIZE = 3'd1,
		REG_BOTTOM_MODE = 3'd2,
		REG_SORT_BY_VALUE = 3'd3,
		REG_CUTOFF_LEVEL = 3'd4
	} cfg_reg_t;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic operation;
		logic [ID_BITS-1:0] item_id;
		logic signed [KEY_BITS-1:0] quantity_key;
		logic signed [KEY_BITS-1:0] value_key;
	} in_item_t;

	typedef struct packed {
		logic [6:0] rank;
		logic [ID_BITS-1:0] out_item_id;
		logic signed [KEY_BITS-1:0] out_quantity;
		logic signed [KEY_BITS-1:0] out_value;
		logic entry_valid;
		logic overflowed;
		logic last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] chart_mode;
		logic [6:0] chart_size;
		logic bottom_mode;
		logic sort_by_value;
		logic [KEY_BITS-1:0] cutoff_level;
	} cfg_t;

	typedef struct packed {
		logic [ID_BITS-1:0] id;
		logic [KEY_BITS-1:0] q;
		logic [KEY_BITS-1:0] v;
	} entry_t;

	// classified item as handed from front to back
	typedef struct packed {
		logic op;
		entry_t ent;
		logic [KEY_BITS-1:0] nk;
	} cmd_t;

	// signed key to unsigned key of the same order
	function automatic logic [KEY_BITS-1:0] biased(input logic [KEY_BITS-1:0] k);
		biased = {~k[KEY_BITS-1], k[KEY_BITS-2:0]};
	endfunction

endpackage

>>> design/tkr_ram.sv
module tkr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic clk,
	input  logic we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/tkr_front.sv
module tkr_front (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  tkr_pkg::in_item_t in_data,
	input  tkr_pkg::cfg_t cfg,
	output logic cmd_valid,
	input  logic cmd_ready,
	output tkr_pkg::cmd_t cmd
);

	tkr_pkg::cmd_t slot_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] fill_q;
	logic push, pop;
	tkr_pkg::cmd_t cls;

	always_comb begin
		cls.op = in_data.operation;
		cls.ent.id = in_data.item_id;
		cls.ent.q = in_data.quantity_key;
		cls.ent.v = in_data.value_key;
		cls.nk = tkr_pkg::biased(cfg.sort_by_value ? in_data.value_key : in_data.quantity_key);
	end

	assign in_stall = (fill_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign cmd_valid = (fill_q != 2'd0);
	assign pop = cmd_valid && cmd_ready;
	assign cmd = slot_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			case ({push, pop})
				2'b10: fill_q <= fill_q + 2'd1;
				2'b01: fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

>>> design/tkr_back.sv
module tkr_back (
	input  logic clk,
	input  logic arst_n,
	input  tkr_pkg::cfg_t cfg,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  tkr_pkg::cmd_t cmd,
	output logic out_valid,
	input  logic out_stall,
	output tkr_pkg::out_item_t out_data
);

	localparam int CB = tkr_pkg::CNT_BITS;
	localparam int IB = tkr_pkg::IDX_BITS;
	localparam int KB = tkr_pkg::KEY_BITS;
	localparam logic [CB-1:0] CAP = CB'(tkr_pkg::CAPACITY);

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_SRCH = 9'b000000010,
		S_CMP = 9'b000000100,
		S_DECIDE = 9'b000001000,
		S_SH_RD = 9'b000010000,
		S_SH_WR = 9'b000100000,
		S_TRIM = 9'b001000000,
		S_FRD = 9'b010000000,
		S_FCHK = 9'b100000000
	} state_t;

	state_t state_q;
	tkr_pkg::cmd_t cur_q;
	logic [CB-1:0] count_q, lo_q, i_q, k_q;
	logic signed [CB:0] hi_q;
	logic [IB-1:0] mid_q;
	logic ovf_q;
	tkr_pkg::entry_t pend_q;
	logic [6:0] pend_rank_q;
	logic have_pend_q;
	logic out_valid_q;
	tkr_pkg::out_item_t out_q;

	logic we, re;
	logic [IB-1:0] waddr, raddr;
	tkr_pkg::entry_t wdata, rdata;

	logic [CB:0] mid_sum;
	logic [KB-1:0] ek, ck;
	logic go_left, stop, kval, out_free, emit;
	logic [CB-1:0] limit;

	tkr_ram #(.WIDTH($bits(tkr_pkg::entry_t)), .DEPTH(tkr_pkg::CAPACITY)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.re(re), .raddr(raddr), .rdata(rdata)
	);

	assign mid_sum = {1'b0, lo_q} + hi_q[CB:0];
	assign ek = tkr_pkg::biased(cfg.sort_by_value ? rdata.v : rdata.q);
	assign ck = tkr_pkg::biased(cfg.cutoff_level);
	assign go_left = cfg.bottom_mode ? (ek > cur_q.nk) : (cur_q.nk >= ek);
	assign stop = cfg.bottom_mode ? (ek > ck) : (ck > ek);
	assign kval = (k_q < count_q) && !(cfg.chart_mode == tkr_pkg::MODE_CUTOFF && stop);
	assign limit = (cfg.chart_size > CAP) ? CAP : cfg.chart_size;
	assign out_free = !out_valid_q || !out_stall;
	assign emit = have_pend_q || !kval;

	assign cmd_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	always_comb begin
		we = 1'b0;
		re = 1'b0;
		waddr = i_q[IB-1:0];
		raddr = mid_sum[IB:1];
		wdata = rdata;
		case (state_q)
			S_SRCH: re = ($signed({1'b0, lo_q}) <= hi_q);
			S_SH_RD: begin
				if (i_q > lo_q) begin
					re = 1'b1;
					raddr = IB'(i_q - CB'(1));
				end else begin
					we = 1'b1;
					waddr = lo_q[IB-1:0];
					wdata = cur_q.ent;
				end
			end
			S_SH_WR: we = 1'b1;
			S_FRD: begin
				re = (k_q < count_q);
				raddr = k_q[IB-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && cmd_valid) cur_q <= cmd;
		if (state_q == S_SRCH) mid_q <= mid_sum[IB:1];
		if (state_q == S_FCHK && out_free && kval) begin
			pend_q <= rdata;
			pend_rank_q <= 7'(k_q + CB'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			lo_q <= '0;
			hi_q <= '0;
			i_q <= '0;
			k_q <= '0;
			ovf_q <= 1'b0;
			have_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.op == tkr_pkg::OP_FLUSH) begin
							k_q <= '0;
							have_pend_q <= 1'b0;
							state_q <= S_FRD;
						end else begin
							lo_q <= '0;
							hi_q <= (CB+1)'($signed({1'b0, count_q}) - 1);
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if ($signed({1'b0, lo_q}) <= hi_q) state_q <= S_CMP;
					else state_q <= S_DECIDE;
				end
				S_CMP: begin
					if (go_left) hi_q <= (CB+1)'($signed({2'b00, mid_q}) - 1);
					else lo_q <= CB'(mid_q) + CB'(1);
					state_q <= S_SRCH;
				end
				S_DECIDE: begin
					if (cfg.chart_mode != tkr_pkg::MODE_MAX_ITEMS) begin
						if (count_q >= CAP) begin
							ovf_q <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							i_q <= count_q;
							state_q <= S_SH_RD;
						end
					end else if (lo_q < limit) begin
						if (count_q >= CAP) begin
							count_q <= CAP - CB'(1);
							i_q <= CAP - CB'(1);
						end else begin
							i_q <= count_q;
						end
						state_q <= S_SH_RD;
					end else begin
						if (count_q > limit) count_q <= count_q - CB'(1);
						state_q <= S_IDLE;
					end
				end
				S_SH_RD: begin
					if (i_q > lo_q) begin
						state_q <= S_SH_WR;
					end else begin
						count_q <= count_q + CB'(1);
						state_q <= S_TRIM;
					end
				end
				S_SH_WR: begin
					i_q <= i_q - CB'(1);
					state_q <= S_SH_RD;
				end
				S_TRIM: begin
					if (cfg.chart_mode == tkr_pkg::MODE_MAX_ITEMS && count_q > limit)
						count_q <= count_q - CB'(1);
					state_q <= S_IDLE;
				end
				S_FRD: state_q <= S_FCHK;
				S_FCHK: begin
					if (out_free) begin
						if (emit) begin
							out_valid_q <= 1'b1;
							out_q.overflowed <= ovf_q;
							out_q.last <= !kval;
							if (have_pend_q) begin
								out_q.rank <= pend_rank_q;
								out_q.out_item_id <= pend_q.id;
								out_q.out_quantity <= pend_q.q;
								out_q.out_value <= pend_q.v;
								out_q.entry_valid <= 1'b1;
							end else begin
								out_q.rank <= '0;
								out_q.out_item_id <= '0;
								out_q.out_quantity <= '0;
								out_q.out_value <= '0;
								out_q.entry_valid <= 1'b0;
							end
						end
						if (kval) begin
							have_pend_q <= 1'b1;
							k_q <= k_q + CB'(1);
							state_q <= S_FRD;
						end else begin
							have_pend_q <= 1'b0;
							count_q <= '0;
							ovf_q <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> design/top_k_ranked_list_top.sv
// Top-k ranked list: keeps up to 64 entries (id, quantity, value) ranked by one key.
// Input channel in_valid/in_stall/in_data: operation 0 inserts an item, 1 flushes.
// Output channel out_valid/out_stall/out_data: one transaction per emitted entry in
// rank order, last set on the final one; a flush with nothing to emit gives one
// transaction with entry_valid 0. Inserts produce no output.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data, always ready; write only
// while the block is idle.
// A two-entry queue in front takes items while the engine works. An insert runs a
// binary search over the list memory (up to 7 steps), then shifts each entry behind
// the new position down one place, a read and a write per entry, to open the slot.
// A flush reads the entries in rank order and streams them out through a pending
// register and the output register.
// An output register holds a result while out_stall is high; the engine waits on it
// and the input queue fills, then raises in_stall.
// Reset (arst_n low) empties the list and the queue, clears the overflow flag and
// loads chart_mode 0, chart_size 64, others 0. No memory clearing pass is needed.
module top_k_ranked_list_top (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  tkr_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output tkr_pkg::out_item_t out_data,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [tkr_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [tkr_pkg::KEY_BITS-1:0] cfg_data
);

	tkr_pkg::cfg_t cfg_q;
	logic cmd_valid, cmd_ready;
	tkr_pkg::cmd_t cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chart_mode <= tkr_pkg::MODE_MAX_ITEMS;
			cfg_q.chart_size <= 7'(tkr_pkg::CAPACITY);
			cfg_q.bottom_mode <= 1'b0;
			cfg_q.sort_by_value <= 1'b0;
			cfg_q.cutoff_level <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tkr_pkg::REG_CHART_MODE: cfg_q.chart_mode <= cfg_data[1:0];
				tkr_pkg::REG_CHART_SIZE: cfg_q.chart_size <= cfg_data[6:0];
				tkr_pkg::REG_BOTTOM_MODE: cfg_q.bottom_mode <= cfg_data[0];
				tkr_pkg::REG_SORT_BY_VALUE: cfg_q.sort_by_value <= cfg_data[0];
				tkr_pkg::REG_CUTOFF_LEVEL: cfg_q.cutoff_level <= cfg_data;
				default: ;
			endcase
		end
	end

	tkr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.cfg(cfg_q),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	tkr_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
	);

endmodule

>>> tb/top_k_ranked_list_top_tb.sv
`timescale 1ns / 1ps

module top_k_ranked_list_top_tb;
	import tkr_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [KEY_BITS-1:0] cfg_data = '0;

	top_k_ranked_list_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the ranked list
	entry_t list_mem [CAPACITY];
	int list_len;
	bit ovf_seen;
	logic [1:0] sh_mode;
	logic [6:0] sh_size;
	bit sh_bottom, sh_by_value;
	logic [KEY_BITS-1:0] sh_cutoff;

	out_item_t pending_q[$];
	int errors = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_recv = 1'b0;

	function automatic logic [KEY_BITS-1:0] rank_key(entry_t e);
		logic [KEY_BITS-1:0] k;
		k = sh_by_value ? e.v : e.q;
		return {~k[KEY_BITS-1], k[KEY_BITS-2:0]};
	endfunction

	function automatic void rank_insert(entry_t e);
		int lo, hi, mid, lim;
		logic [KEY_BITS-1:0] nk, ek;
		bit go_left;
		lo = 0;
		hi = list_len - 1;
		nk = rank_key(e);
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			ek = rank_key(list_mem[mid]);
			go_left = sh_bottom ? (ek > nk) : (nk >= ek);
			if (go_left) hi = mid - 1;
			else lo = mid + 1;
		end
		if (sh_mode != MODE_MAX_ITEMS) begin
			if (list_len >= CAPACITY) begin
				ovf_seen = 1'b1;
				return;
			end
		end else begin
			lim = (sh_size > CAPACITY) ? CAPACITY : sh_size;
			if (lo < lim) begin
				if (list_len >= CAPACITY) list_len = CAPACITY - 1;
			end else begin
				if (list_len > lim) list_len--;
				return;
			end
		end
		for (int i = list_len; i > lo; i--) list_mem[i] = list_mem[i-1];
		list_mem[lo] = e;
		list_len++;
		if (sh_mode == MODE_MAX_ITEMS && list_len > lim) list_len--;
	endfunction

	function automatic void rank_flush();
		int n;
		logic [KEY_BITS-1:0] ck, ek;
		out_item_t r;
		n = 0;
		if (sh_mode == MODE_CUTOFF) begin
			ck = {~sh_cutoff[KEY_BITS-1], sh_cutoff[KEY_BITS-2:0]};
			while (n < list_len) begin
				ek = rank_key(list_mem[n]);
				if (sh_bottom ? (ek > ck) : (ck > ek)) break;
				n++;
			end
		end else n = list_len;
		if (n == 0) begin
			r = '0;
			r.overflowed = ovf_seen;
			r.last = 1'b1;
			pending_q.push_back(r);
		end
		for (int k = 0; k < n; k++) begin
			r.rank = 7'(k + 1);
			r.out_item_id = list_mem[k].id;
			r.out_quantity = list_mem[k].q;
			r.out_value = list_mem[k].v;
			r.entry_valid = 1'b1;
			r.overflowed = ovf_seen;
			r.last = (k + 1 == n);
			pending_q.push_back(r);
		end
		list_len = 0;
		ovf_seen = 1'b0;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [KEY_BITS-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CHART_MODE: sh_mode = val[1:0];
			REG_CHART_SIZE: sh_size = val[6:0];
			REG_BOTTOM_MODE: sh_bottom = val[0];
			REG_SORT_BY_VALUE: sh_by_value = val[0];
			REG_CUTOFF_LEVEL: sh_cutoff = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// in_valid stays high after a transaction; a pause before the next item or drain() takes it down
	task automatic send_item(in_item_t it);
		entry_t e;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		if (it.operation == OP_INSERT) begin
			e.id = it.item_id;
			e.q = it.quantity_key;
			e.v = it.value_key;
			rank_insert(e);
		end else rank_flush();
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [KEY_BITS-1:0] rand_key(int style);
		logic [KEY_BITS-1:0] k;
		case (style)
			0: k = KEY_BITS'({$urandom, $urandom});
			1: k = KEY_BITS'($signed($urandom_range(20)) - 10);
			2: k = {1'b0, {(KEY_BITS-1){1'b1}}};
			default: k = {1'b1, {(KEY_BITS-1){1'b0}}};
		endcase
		return k;
	endfunction

	function automatic in_item_t rand_insert(int n_ids);
		in_item_t it;
		it.operation = OP_INSERT;
		it.item_id = (n_ids == 0) ? 16'($urandom) : 16'($urandom_range(n_ids));
		it.quantity_key = rand_key($urandom_range(9) < 5 ? 0 : $urandom_range(3));
		it.value_key = rand_key($urandom_range(9) < 5 ? 0 : $urandom_range(3));
		return it;
	endfunction

	// checker
	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_q.size() == 0) begin
				$error("unexpected result transaction %h", out_data);
				errors++;
			end else begin
				exp_r = pending_q.pop_front();
				if (out_data.rank !== exp_r.rank) begin
					$error("rank exp %0d got %0d", exp_r.rank, out_data.rank); errors++;
				end
				if (out_data.out_item_id !== exp_r.out_item_id) begin
					$error("out_item_id exp %h got %h", exp_r.out_item_id,
						out_data.out_item_id); errors++;
				end
				if (out_data.out_quantity !== exp_r.out_quantity) begin
					$error("out_quantity exp %h got %h", exp_r.out_quantity,
						out_data.out_quantity); errors++;
				end
				if (out_data.out_value !== exp_r.out_value) begin
					$error("out_value exp %h got %h", exp_r.out_value,
						out_data.out_value); errors++;
				end
				if (out_data.entry_valid !== exp_r.entry_valid) begin
					$error("entry_valid exp %b got %b", exp_r.entry_valid,
						out_data.entry_valid); errors++;
				end
				if (out_data.overflowed !== exp_r.overflowed) begin
					$error("overflowed exp %b got %b", exp_r.overflowed,
						out_data.overflowed); errors++;
				end
				if (out_data.last !== exp_r.last) begin
					$error("last exp %b got %b", exp_r.last, out_data.last); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
	end

	// directed table; typed-in expectations only for the empty flushes
	typedef struct {
		in_item_t it;
		bit has_exp;
		out_item_t exp_r;
	} dir_row_t;

	initial begin
		#20000000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		dir_row_t rows[$];
		dir_row_t row;
		in_item_t it;
		out_item_t empty_r;
		logic [KEY_BITS-1:0] kmax, kmin;
		int n;

		kmax = {1'b0, {(KEY_BITS-1){1'b1}}};
		kmin = {1'b1, {(KEY_BITS-1){1'b0}}};
		list_len = 0;
		ovf_seen = 0;
		sh_mode = MODE_MAX_ITEMS;
		sh_size = 7'd64;
		sh_bottom = 0;
		sh_by_value = 0;
		sh_cutoff = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		empty_r = '0;
		empty_r.last = 1'b1;
		// flush after reset, extremes, equal keys, second flush empty
		row.has_exp = 1; row.it = '0; row.it.operation = OP_FLUSH; row.exp_r = empty_r;
		rows.push_back(row);
		row.has_exp = 0;
		row.it = '{OP_INSERT, 16'hffff, kmax, kmin}; rows.push_back(row);
		row.it = '{OP_INSERT, 16'h0000, kmin, kmax}; rows.push_back(row);
		row.it = '{OP_INSERT, 16'h1234, 48'd5, 48'd5}; rows.push_back(row);
		row.it = '{OP_INSERT, 16'h1235, 48'd5, -48'sd5}; rows.push_back(row);
		row.it = '{OP_INSERT, 16'h1236, 48'd0, 48'd0}; rows.push_back(row);
		row.it = '{OP_FLUSH, 16'hffff, kmax, kmax}; rows.push_back(row);
		row.has_exp = 1; row.it = '0; row.it.operation = OP_FLUSH; rows.push_back(row);
		foreach (rows[i]) begin
			send_item(rows[i].it);
			if (rows[i].has_exp) begin
				void'(pending_q.pop_back());
				pending_q.push_back(rows[i].exp_r);
			end
		end
		drain();

		// several settings, each phase with one of four idling patterns
		for (int ph = 0; ph < 10; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 51; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 51; end
				default: begin send_idle_pct = 27; recv_stall_pct = 27; end
			endcase
			write_reg(REG_CHART_MODE, (ph == 9) ? KEY_BITS'(3) : KEY_BITS'(ph % 3));
			write_reg(REG_CHART_SIZE, (ph == 0) ? KEY_BITS'(1) : (ph == 3) ? KEY_BITS'(127) :
				(ph == 6) ? KEY_BITS'(0) : KEY_BITS'($urandom_range(64, 2)));
			write_reg(REG_BOTTOM_MODE, KEY_BITS'(ph[0]));
			write_reg(REG_SORT_BY_VALUE, KEY_BITS'(ph[1]));
			write_reg(REG_CUTOFF_LEVEL, (ph == 4) ? kmax : (ph == 7) ? kmin :
				rand_key($urandom_range(1)));
			n = 0;
			while (n < 27) begin
				if ($urandom_range(9) == 0) begin
					it = rand_insert(0);
					it.operation = OP_FLUSH;
				end else it = rand_insert(ph > 5 ? 0 : 50);
				send_item(it);
				n++;
			end
			// overflow the list in a keep mode
			if (ph == 5 || ph == 9) begin
				for (int j = 0; j < 70; j++) send_item(rand_insert(0));
			end
			it = rand_insert(0);
			it.operation = OP_FLUSH;
			if (ph == 2) begin
				fork
					begin
						hold_recv = 1'b1;
						repeat (400) @(posedge clk);
						hold_recv = 1'b0;
					end
					begin
						for (int j = 0; j < 20; j++) begin
							send_item(it);
							send_item(rand_insert(0));
						end
					end
				join
			end
			send_item(it);
			drain();
		end

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
